// File: rtl/mmmtm_pkg.sv
// Shared types and constants for the min/max/mean threshold monitor.
`default_nettype none

package mmmtm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 32;
  localparam int SUM_W    = SAMPLE_W + COUNT_W;
  localparam int TICK_W   = 32;
  localparam int QUOT_W   = SAMPLE_W;
  localparam int QSTEP_W  = $clog2(QUOT_W);
  localparam int ACTION_W = 2;
  localparam int OUT_W    = 3 * SAMPLE_W + COUNT_W + 1 + TICK_W;
  localparam int OUT_PAD  = ((OUT_W + 7) / 8) * 8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
  localparam logic [TICK_W-1:0]   TICK_MAX   = {TICK_W{1'b1}};
  localparam logic [SUM_W-1:0]    SUM_LIMIT  =
    SUM_W'(SAMPLE_MAX) * SUM_W'(COUNT_MAX);

  typedef enum logic [ACTION_W-1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_ENABLE    = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

endpackage

`default_nettype wire

// File: rtl/min_max_mean_threshold_monitor.sv
// Top level of the sensor statistics monitor with time-over-threshold count.
// An accepted beat passes through the update, divide and output states to its result beat.
// The divide state waits for the 16-step quotient loop of the divider.
// The input is not ready while an item is in work; a waiting result holds off the next.
// Reset clears all statistics, the threshold and its enable; no clearing pass is needed.
`default_nettype none

module min_max_mean_threshold_monitor
  import mmmtm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [SAMPLE_W-1:0] s_tdata,  // sample
  input  wire logic [ACTION_W-1:0] s_tuser,  // action
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // max_value, min_value, mean_value, sample_total, over_threshold, over_time, zero pad
  output logic [OUT_PAD-1:0]      m_tdata,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [SAMPLE_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [SAMPLE_W-1:0] threshold;
  logic                threshold_enable;
  logic [SAMPLE_W-1:0] max_seen;
  logic [SAMPLE_W-1:0] min_seen;
  logic [SUM_W-1:0]    running_sum;
  logic [COUNT_W-1:0]  running_count;
  logic                over_flag;
  logic [TICK_W-1:0]   over_ticks;
  action_t             action;
  logic [SAMPLE_W-1:0] sample;

  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   quotient;
  logic [SUM_W:0]      sum_add;
  logic [SAMPLE_W-1:0] mean;
  logic                load_out;

  assign cfg_ready = 1'b1;
  assign sum_add   = {1'b0, running_sum} + (SUM_W + 1)'(sample);
  assign mean      = (running_count == '0) ? '0 : quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (!div_start && div_done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_UPDATE) begin
      div_start = 1'b0;
    end
  end

  // The divider starts on the first cycle of the divide state, after the
  // statistics have taken this item.
  logic div_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_first <= 1'b0;
    end else begin
      div_first <= (state == ST_UPDATE);
    end
  end

  mmmtm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_first),
    .dividend (running_sum),
    .divisor  (running_count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      action <= action_t'(s_tuser);
      sample <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= '0;
      threshold_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESHOLD: threshold        <= cfg_data;
        REG_ENABLE:    threshold_enable <= cfg_data[0];
        default:       threshold        <= threshold;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seen      <= '0;
      min_seen      <= '0;
      running_sum   <= '0;
      running_count <= '0;
      over_flag     <= 1'b0;
      over_ticks    <= '0;
    end else if (state == ST_UPDATE) begin
      unique case (action)
        ACT_SAMPLE: begin
          if (running_count == '0) begin
            max_seen <= sample;
            min_seen <= sample;
          end else begin
            if (sample > max_seen) begin
              max_seen <= sample;
            end
            if (sample < min_seen) begin
              min_seen <= sample;
            end
          end
          if (running_count != COUNT_MAX) begin
            running_count <= running_count + 1'b1;
            running_sum   <= (sum_add > {1'b0, SUM_LIMIT}) ? SUM_LIMIT
                                                           : sum_add[SUM_W-1:0];
          end
          if (threshold_enable) begin
            over_flag <= sample > threshold;
          end
        end
        ACT_TICK: begin
          if (threshold_enable && over_flag && over_ticks != TICK_MAX) begin
            over_ticks <= over_ticks + 1'b1;
          end
        end
        ACT_RESTART: begin
          max_seen      <= '0;
          min_seen      <= '0;
          running_sum   <= '0;
          running_count <= '0;
          over_flag     <= 1'b0;
          over_ticks    <= '0;
        end
        default: begin
          over_flag <= over_flag;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {(OUT_PAD - OUT_W)'(0), over_ticks, over_flag, running_count,
                  mean, min_seen, max_seen};
    end
  end

endmodule

`default_nettype wire

// File: rtl/mmmtm_div.sv
// Restoring divider that produces a 16-bit quotient one bit per cycle.
`default_nettype none

module mmmtm_div
  import mmmtm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire logic [COUNT_W-1:0] divisor,
  output logic                    done,
  output logic [QUOT_W-1:0]       quotient
);

  logic [COUNT_W-1:0] rem;
  logic [QUOT_W-1:0]  shreg;
  logic [COUNT_W-1:0] dvsr;
  logic [QSTEP_W-1:0] step;
  logic               busy;
  logic [COUNT_W:0]   trial;
  logic               fits;

  // The quotient never exceeds the largest sample, so the upper part of the
  // dividend is already below the divisor and only the low bits need steps.
  assign trial = {rem, shreg[QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == QSTEP_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend[SUM_W-1:QUOT_W];
      shreg <= dividend[QUOT_W-1:0];
      dvsr  <= divisor;
    end else if (busy) begin
      rem   <= fits ? COUNT_W'(trial - {1'b0, dvsr}) : trial[COUNT_W-1:0];
      shreg <= {shreg[QUOT_W-2:0], fits};
    end
  end

  assign quotient = shreg;

endmodule

`default_nettype wire

// File: test/tb_min_max_mean_threshold_monitor.sv
// Self-checking testbench for the min/max/mean threshold monitor with a scoreboard class.
`timescale 1ns / 100ps

module tb_min_max_mean_threshold_monitor;
  import mmmtm_pkg::*;

  localparam int MIN_LO  = SAMPLE_W;
  localparam int MEAN_LO = 2 * SAMPLE_W;
  localparam int TOT_LO  = 3 * SAMPLE_W;
  localparam int OVR_BIT = TOT_LO + COUNT_W;
  localparam int OT_LO   = OVR_BIT + 1;
  localparam int PHASES  = 6;
  localparam int PHASE_ITEMS = 150;

  typedef struct {
    logic [SAMPLE_W-1:0] max_value;
    logic [SAMPLE_W-1:0] min_value;
    logic [SAMPLE_W-1:0] mean_value;
    logic [COUNT_W-1:0]  sample_total;
    logic                over_threshold;
    logic [TICK_W-1:0]   over_time;
  } stats_t;

  class stats_scoreboard;
    stats_t              expected_q[$];
    logic [SAMPLE_W-1:0] threshold_lvl;
    logic                check_en;
    logic [SAMPLE_W-1:0] peak;
    logic [SAMPLE_W-1:0] trough;
    logic [SUM_W-1:0]    acc_sum;
    logic [COUNT_W-1:0]  n_samples;
    logic                flag;
    logic [TICK_W-1:0]   tick_total;
    int errors;
    int checked;
    int flag_hits;
    int n_smp;
    int n_tick;
    int n_rst;
    int n_skip;

    function new();
      threshold_lvl = '0;
      check_en = 1'b0;
      errors = 0;
      checked = 0;
      flag_hits = 0;
      n_smp = 0;
      n_tick = 0;
      n_rst = 0;
      n_skip = 0;
      clear_session();
    endfunction

    function void clear_session();
      peak = '0;
      trough = '0;
      acc_sum = '0;
      n_samples = '0;
      flag = 1'b0;
      tick_total = '0;
    endfunction

    function void write_reg(reg_index_t idx, logic [SAMPLE_W-1:0] val);
      if (idx == REG_THRESHOLD) begin
        threshold_lvl = val;
      end else begin
        check_en = val[0];
      end
    endfunction

    function void note_input(action_t act, logic [SAMPLE_W-1:0] s);
      stats_t e;
      case (act)
        ACT_SAMPLE: begin
          n_smp++;
          if (n_samples == 0) begin
            peak = s;
            trough = s;
          end else begin
            if (s > peak) peak = s;
            if (s < trough) trough = s;
          end
          if (n_samples != COUNT_MAX) begin
            n_samples++;
            if (acc_sum > SUM_LIMIT - SUM_W'(s)) begin
              acc_sum = SUM_LIMIT;
            end else begin
              acc_sum += SUM_W'(s);
            end
          end
          if (check_en) flag = (s > threshold_lvl);
        end
        ACT_TICK: begin
          n_tick++;
          if (check_en && flag && tick_total != TICK_MAX) tick_total++;
        end
        ACT_RESTART: begin
          n_rst++;
          clear_session();
        end
        default: begin
          n_skip++;
        end
      endcase
      e.max_value = peak;
      e.min_value = trough;
      e.mean_value = (n_samples != 0) ? SAMPLE_W'(acc_sum / SUM_W'(n_samples)) : '0;
      e.sample_total = n_samples;
      e.over_threshold = flag;
      e.over_time = tick_total;
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [COUNT_W-1:0] got, logic [COUNT_W-1:0] want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_PAD-1:0] beat);
      stats_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result beat, max_value", beat[SAMPLE_W-1:0], 0);
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (e.over_threshold) flag_hits++;
        if (beat[0 +: SAMPLE_W] !== e.max_value)
          report("max_value", beat[0 +: SAMPLE_W], e.max_value);
        if (beat[MIN_LO +: SAMPLE_W] !== e.min_value)
          report("min_value", beat[MIN_LO +: SAMPLE_W], e.min_value);
        if (beat[MEAN_LO +: SAMPLE_W] !== e.mean_value)
          report("mean_value", beat[MEAN_LO +: SAMPLE_W], e.mean_value);
        if (beat[TOT_LO +: COUNT_W] !== e.sample_total)
          report("sample_total", beat[TOT_LO +: COUNT_W], e.sample_total);
        if (beat[OVR_BIT] !== e.over_threshold)
          report("over_threshold", beat[OVR_BIT], e.over_threshold);
        if (beat[OT_LO +: TICK_W] !== e.over_time)
          report("over_time", beat[OT_LO +: TICK_W], e.over_time);
      end
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata;
  logic [ACTION_W-1:0] s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_PAD-1:0]  m_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [SAMPLE_W-1:0] cfg_data;

  stats_scoreboard sb;
  logic            src_quiet;

  min_max_mean_threshold_monitor DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(action_t act, logic [SAMPLE_W-1:0] s);
    int gap;
    gap = src_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= s;
    do @(posedge clk); while (!s_tready);
    sb.note_input(act, s);
  endtask

  task automatic write_reg(reg_index_t idx, logic [SAMPLE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [SAMPLE_W-1:0] thr, logic en);
    drain();
    @(posedge clk);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_ENABLE, {(SAMPLE_W - 1)'($urandom_range(0, 32767)), en});
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(50, 200)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int n_items;
    int v;
    int r;
    int p;
    int settings;
    logic [SAMPLE_W-1:0] thr;
    logic en;
    action_t act;
    logic [SAMPLE_W-1:0] smp;

    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_SAMPLE;
    cfg_valid = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    src_quiet = 1'b0;
    settings = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: threshold disabled, no samples in the session yet.
    send_item(ACT_TICK, 16'h0000);
    send_item(ACT_NONE, 16'hFFFF);
    send_item(ACT_SAMPLE, 16'h1234);
    send_item(ACT_TICK, 16'h0000);
    send_item(ACT_SAMPLE, 16'hFFFF);
    send_item(ACT_SAMPLE, 16'h0000);
    send_item(ACT_NONE, 16'h5A5A);
    send_item(ACT_RESTART, 16'h0000);

    set_config(16'h0000, 1'b1);
    send_item(ACT_SAMPLE, 16'h0000);
    send_item(ACT_SAMPLE, 16'h0001);
    send_item(ACT_TICK, 16'h0000);
    send_item(ACT_TICK, 16'hFFFF);
    send_item(ACT_SAMPLE, 16'h0000);
    send_item(ACT_TICK, 16'h0000);

    set_config(16'hFFFF, 1'b1);
    send_item(ACT_SAMPLE, 16'hFFFF);
    send_item(ACT_TICK, 16'h0000);

    // The flag must hold while checking is switched off.
    set_config(16'd100, 1'b1);
    send_item(ACT_RESTART, 16'h0000);
    send_item(ACT_SAMPLE, 16'd200);
    set_config(16'd100, 1'b0);
    send_item(ACT_TICK, 16'h0000);
    send_item(ACT_SAMPLE, 16'h0000);
    set_config(16'd100, 1'b1);
    send_item(ACT_TICK, 16'h0000);
    settings += 5;

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: thr = 16'h0000;
        1: thr = 16'hFFFF;
        default: thr = SAMPLE_W'($urandom_range(0, 65535));
      endcase
      en = (p % 3 != 2);
      set_config(thr, en);
      settings++;
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        if (n_items % 50 == 0) src_quiet = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        smp = SAMPLE_W'($urandom_range(0, 65535));
        if (r < 58) begin
          act = ACT_SAMPLE;
          r = $urandom_range(0, 99);
          if (r < 40) begin
            v = int'(thr) + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            smp = SAMPLE_W'(v);
          end else if (r < 55) begin
            smp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          end
        end else if (r < 88) begin
          act = ACT_TICK;
        end else if (r < 93) begin
          act = ACT_RESTART;
        end else begin
          act = ACT_NONE;
        end
        send_item(act, smp);
        if (act != ACT_NONE) n_items++;
      end
    end

    src_quiet = 1'b0;
    drain();
    repeat (25) @(posedge clk);
    $display("Covered %0d samples, %0d ticks, %0d restarts and %0d unused-action beats",
             sb.n_smp, sb.n_tick, sb.n_rst, sb.n_skip);
    $display("over %0d threshold settings; %0d results checked, %0d with the flag set.",
             settings, sb.checked, sb.flag_hits);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/mmmtm_pkg.sv
rtl/mmmtm_div.sv
rtl/min_max_mean_threshold_monitor.sv
test/tb_min_max_mean_threshold_monitor.sv
